// ===== src/bertlv_pkg.sv =====
// ----------------------------------------------------------------------------
// bertlv_pkg
// Shared types and constants of the BER TLV header parser.
// ----------------------------------------------------------------------------
package bertlv_pkg;

	localparam int TAG_BITS_DEF  = 31;
	localparam int MAX_DEPTH_DEF = 64;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN_OCTETS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TAG_STOP_HIGH  = 1'd1;

	localparam logic [3:0] MAX_LEN_OCTETS_RST = 4'd8;
	localparam logic [3:0] LEN_OCTETS_CAP     = 4'd8;

	localparam logic [2:0] PH_IDENT  = 3'd0;
	localparam logic [2:0] PH_TAG    = 3'd1;
	localparam logic [2:0] PH_LEN    = 3'd2;
	localparam logic [2:0] PH_LENOCT = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;
	localparam logic [2:0] PH_EOC    = 3'd5;

	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_CONTENT = 2'd1;
	localparam logic [1:0] KIND_EOC     = 2'd2;
	localparam logic [1:0] KIND_ERROR   = 2'd3;

	localparam logic [3:0] ERR_NONE          = 4'd0;
	localparam logic [3:0] ERR_TAG_OVERFLOW  = 4'd1;
	localparam logic [3:0] ERR_CONS_DEFINITE = 4'd2;
	localparam logic [3:0] ERR_PRIM_INDEF    = 4'd3;
	localparam logic [3:0] ERR_LEN_OCTETS    = 4'd4;
	localparam logic [3:0] ERR_LEN_LEADZERO  = 4'd5;
	localparam logic [3:0] ERR_EOC_LENGTH    = 4'd6;
	localparam logic [3:0] ERR_EOC_DEPTH0    = 4'd7;
	localparam logic [3:0] ERR_DEPTH_OVF     = 4'd8;

	localparam logic [7:0] BYTE_INDEF   = 8'h80;
	localparam logic [4:0] TAG_LONG_ESC = 5'h1f;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  tag_class;
		logic        is_constructed;
		logic [30:0] tag_number;
		logic [63:0] content_length;
		logic        is_indefinite;
		logic [7:0]  content_byte;
		logic        last_content;
		logic [6:0]  nest_depth;
		logic [3:0]  error_code;
	} out_item_t;

	typedef struct packed {
		logic [3:0] max_length_octets;
		logic       tag_stop_on_high_bit;
	} cfg_t;

endpackage

// ===== src/ber_tlv_header_parser.sv =====
// ----------------------------------------------------------------------------
// ber_tlv_header_parser
// BER TLV header parser: one byte per request, at most one result per byte.
// ----------------------------------------------------------------------------
// throughput: one byte per cycle, limited only by output stall
// input register, combinational parse logic, then the result register
// reset: parse state cleared, max_length_octets 8, tag_stop_on_high_bit 1
// ----------------------------------------------------------------------------
module ber_tlv_header_parser #(
	parameter int TAG_BITS  = bertlv_pkg::TAG_BITS_DEF,
	parameter int MAX_DEPTH = bertlv_pkg::MAX_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  bertlv_pkg::in_item_t                in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output bertlv_pkg::out_item_t               out_data,
	input  logic                                cfg_we,
	input  logic [bertlv_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bertlv_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	logic                  valid_s1;
	bertlv_pkg::in_item_t  data_s1;
	bertlv_pkg::cfg_t      cfg_q;
	bertlv_pkg::out_item_t res;
	logic                  emit;
	logic                  out_ready;
	logic                  adv;

	assign in_stall = valid_s1 && !out_ready;
	assign adv      = valid_s1 && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_length_octets    <= bertlv_pkg::MAX_LEN_OCTETS_RST;
			cfg_q.tag_stop_on_high_bit <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				bertlv_pkg::CFG_MAX_LEN_OCTETS: begin
					cfg_q.max_length_octets <= cfg_wdata[3:0];
				end
				bertlv_pkg::CFG_TAG_STOP_HIGH: begin
					cfg_q.tag_stop_on_high_bit <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	bertlv_core #(
		.TAG_BITS  (TAG_BITS),
		.MAX_DEPTH (MAX_DEPTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (data_s1),
		.cfg    (cfg_q),
		.emit   (emit),
		.res    (res)
	);

	bertlv_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && emit),
		.din       (res),
		.ready     (out_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ===== src/bertlv_core.sv =====
// ----------------------------------------------------------------------------
// bertlv_core
// Parse state and the per-byte next-state and result logic.
// ----------------------------------------------------------------------------
module bertlv_core #(
	parameter int TAG_BITS  = bertlv_pkg::TAG_BITS_DEF,
	parameter int MAX_DEPTH = bertlv_pkg::MAX_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  bertlv_pkg::in_item_t  item,
	input  bertlv_pkg::cfg_t      cfg,
	output logic                  emit,
	output bertlv_pkg::out_item_t res
);

	localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);
	localparam logic [TAG_BITS-1:0] TAG_LIMIT = TAG_BITS'(1) << (TAG_BITS - 7);

	logic [2:0]          phase_q, ph;
	logic [TAG_BITS-1:0] tag_q, ta;
	logic [2:0]          cc_q, cc;
	logic [63:0]         len_q, la;
	logic [3:0]          lol_q, lo;
	logic [63:0]         cl_q, cl;
	logic [DEPTH_W-1:0]  depth_q, dp;
	logic                halt_q, hl;

	logic [1:0]  r_kind;
	logic        r_ident;
	logic [63:0] r_len;
	logic        r_indef;
	logic [7:0]  r_cbyte;
	logic        r_last;
	logic [3:0]  r_err;
	logic [3:0]  lim;
	logic [7:0]  b;

	assign b   = item.data_byte;
	assign lim = (cfg.max_length_octets > bertlv_pkg::LEN_OCTETS_CAP) ?
		bertlv_pkg::LEN_OCTETS_CAP : cfg.max_length_octets;

	always_comb begin
		ph = phase_q;
		ta = tag_q;
		cc = cc_q;
		la = len_q;
		lo = lol_q;
		cl = cl_q;
		dp = depth_q;
		hl = halt_q;
		emit    = 1'b0;
		r_kind  = bertlv_pkg::KIND_HEADER;
		r_ident = 1'b0;
		r_len   = '0;
		r_indef = 1'b0;
		r_cbyte = '0;
		r_last  = 1'b0;
		r_err   = bertlv_pkg::ERR_NONE;
		if (item.restart) begin
			ph = bertlv_pkg::PH_IDENT;
			ta = '0;
			cc = '0;
			la = '0;
			lo = '0;
			cl = '0;
			dp = '0;
			hl = 1'b0;
		end
		if (!hl) begin
			case (ph)
				bertlv_pkg::PH_IDENT: begin
					if (b == 8'd0) begin
						if (dp == '0) begin
							emit   = 1'b1;
							r_kind = bertlv_pkg::KIND_ERROR;
							r_err  = bertlv_pkg::ERR_EOC_DEPTH0;
						end else begin
							ph = bertlv_pkg::PH_EOC;
						end
					end else begin
						cc = b[7:5];
						if (b[4:0] != bertlv_pkg::TAG_LONG_ESC) begin
							ta = TAG_BITS'(b[4:0]);
							ph = bertlv_pkg::PH_LEN;
						end else begin
							ta = '0;
							ph = bertlv_pkg::PH_TAG;
						end
					end
				end
				bertlv_pkg::PH_TAG: begin
					if (ta >= TAG_LIMIT) begin
						emit   = 1'b1;
						r_kind = bertlv_pkg::KIND_ERROR;
						r_err  = bertlv_pkg::ERR_TAG_OVERFLOW;
					end else begin
						ta = {ta[TAG_BITS-8:0], b[6:0]};
						if (b[7] == cfg.tag_stop_on_high_bit) begin
							ph = bertlv_pkg::PH_LEN;
						end
					end
				end
				bertlv_pkg::PH_LEN: begin
					if (cc[0]) begin
						if (b != bertlv_pkg::BYTE_INDEF) begin
							emit   = 1'b1;
							r_kind = bertlv_pkg::KIND_ERROR;
							r_err  = bertlv_pkg::ERR_CONS_DEFINITE;
						end else if (dp >= DEPTH_MAX) begin
							emit   = 1'b1;
							r_kind = bertlv_pkg::KIND_ERROR;
							r_err  = bertlv_pkg::ERR_DEPTH_OVF;
						end else begin
							dp      = dp + DEPTH_W'(1);
							ph      = bertlv_pkg::PH_IDENT;
							emit    = 1'b1;
							r_ident = 1'b1;
							r_indef = 1'b1;
						end
					end else if (b == bertlv_pkg::BYTE_INDEF) begin
						emit   = 1'b1;
						r_kind = bertlv_pkg::KIND_ERROR;
						r_err  = bertlv_pkg::ERR_PRIM_INDEF;
					end else if (!b[7]) begin
						emit    = 1'b1;
						r_ident = 1'b1;
						r_len   = 64'(b[6:0]);
						if (b[6:0] == 7'd0) begin
							ph = bertlv_pkg::PH_IDENT;
						end else begin
							ph = bertlv_pkg::PH_DATA;
							cl = 64'(b[6:0]);
						end
					end else if (b[6:0] > 7'(lim)) begin
						emit   = 1'b1;
						r_kind = bertlv_pkg::KIND_ERROR;
						r_err  = bertlv_pkg::ERR_LEN_OCTETS;
					end else begin
						lo = b[3:0];
						la = '0;
						ph = bertlv_pkg::PH_LENOCT;
					end
				end
				bertlv_pkg::PH_LENOCT: begin
					if (la == '0 && b == 8'd0) begin
						emit   = 1'b1;
						r_kind = bertlv_pkg::KIND_ERROR;
						r_err  = bertlv_pkg::ERR_LEN_LEADZERO;
					end else begin
						la = {la[55:0], b};
						if (lo != '0) begin
							lo = lo - 4'd1;
						end
						if (lo == '0) begin
							emit    = 1'b1;
							r_ident = 1'b1;
							r_len   = la;
							if (la == '0) begin
								ph = bertlv_pkg::PH_IDENT;
							end else begin
								ph = bertlv_pkg::PH_DATA;
								cl = la;
							end
						end
					end
				end
				bertlv_pkg::PH_DATA: begin
					r_last = (cl <= 64'd1);
					if (cl != '0) begin
						cl = cl - 64'd1;
					end
					if (cl == '0) begin
						ph = bertlv_pkg::PH_IDENT;
					end
					emit    = 1'b1;
					r_kind  = bertlv_pkg::KIND_CONTENT;
					r_ident = 1'b1;
					r_cbyte = b;
				end
				bertlv_pkg::PH_EOC: begin
					if (b != 8'd0) begin
						emit   = 1'b1;
						r_kind = bertlv_pkg::KIND_ERROR;
						r_err  = bertlv_pkg::ERR_EOC_LENGTH;
					end else begin
						if (dp != '0) begin
							dp = dp - DEPTH_W'(1);
						end
						ph     = bertlv_pkg::PH_IDENT;
						emit   = 1'b1;
						r_kind = bertlv_pkg::KIND_EOC;
					end
				end
				default: begin
					ph = bertlv_pkg::PH_IDENT;
				end
			endcase
			if (r_kind == bertlv_pkg::KIND_ERROR && emit) begin
				hl = 1'b1;
				ph = bertlv_pkg::PH_IDENT;
			end
		end
		res.kind           = r_kind;
		res.tag_class      = r_ident ? cc[2:1] : 2'd0;
		res.is_constructed = r_ident ? cc[0] : 1'b0;
		res.tag_number     = r_ident ? 31'(ta) : 31'd0;
		res.content_length = r_len;
		res.is_indefinite  = r_indef;
		res.content_byte   = r_cbyte;
		res.last_content   = r_last;
		res.nest_depth     = 7'(dp);
		res.error_code     = r_err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bertlv_pkg::PH_IDENT;
			tag_q   <= '0;
			cc_q    <= '0;
			len_q   <= '0;
			lol_q   <= '0;
			cl_q    <= '0;
			depth_q <= '0;
			halt_q  <= 1'b0;
		end else if (adv) begin
			phase_q <= ph;
			tag_q   <= ta;
			cc_q    <= cc;
			len_q   <= la;
			lol_q   <= lo;
			cl_q    <= cl;
			depth_q <= dp;
			halt_q  <= hl;
		end
	end

endmodule

// ===== src/bertlv_out_reg.sv =====
// ----------------------------------------------------------------------------
// bertlv_out_reg
// Result register on the output channel.
// ----------------------------------------------------------------------------
module bertlv_out_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  bertlv_pkg::out_item_t din,
	output logic                  ready,
	output logic                  out_valid,
	input  logic                  out_stall,
	output bertlv_pkg::out_item_t out_data
);

	logic                  valid_q;
	bertlv_pkg::out_item_t data_q;

	assign ready     = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load) begin
			data_q <= din;
		end
	end

endmodule
